@@ rtl/lurt_pkg.sv @@
// Shared constants and types for the longest unique run tracker.
package lurt_pkg;

  localparam int LURT_POS_BITS = 16;
  localparam int LURT_ALPHABET = 256;

  // String tag kept beside each table entry. Tag zero marks a cleared entry, so a
  // live string uses tags one up to the all-ones value.
  localparam int LURT_EPOCH_W = 8;

  localparam int CHAR_W = 8;
  localparam int OUT_W  = 16;
  localparam logic [OUT_W-1:0] OUT_MAX = 16'hFFFF;

  // One result word as it leaves the window logic.
  typedef struct packed {
    logic [OUT_W-1:0] window_len;
    logic [OUT_W-1:0] best_len;
    logic             string_done;
    logic             too_long;
  } result_t;

endpackage

@@ rtl/lurt_table_ram.sv @@
// Last-seen-position table: one write port, one read port with registered data.
module lurt_table_ram #(
  parameter int DEPTH  = 256,
  parameter int DATA_W = 16,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/lurt_window.sv @@
// Window state, string tag and the per-word window update.
module lurt_window #(
  parameter int POS_BITS = 16,
  parameter int SYM_W    = 8
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       step,
  input  logic [SYM_W-1:0]                           sym,
  input  logic                                       last,
  input  logic [lurt_pkg::LURT_EPOCH_W+POS_BITS-1:0] ram_rdata,
  input  logic                                       fwd,
  input  logic [lurt_pkg::LURT_EPOCH_W+POS_BITS-1:0] fwd_data,
  output logic                                       wr_en,
  output logic [SYM_W-1:0]                           wr_addr,
  output logic [lurt_pkg::LURT_EPOCH_W+POS_BITS-1:0] wr_data,
  output logic                                       epoch_full,
  output lurt_pkg::result_t                          res
);
  import lurt_pkg::*;

  localparam int EXT_W   = (POS_BITS > OUT_W) ? POS_BITS : OUT_W;
  localparam int ENTRY_W = LURT_EPOCH_W + POS_BITS;
  localparam logic [LURT_EPOCH_W-1:0] EPOCH_FIRST = LURT_EPOCH_W'(1);
  localparam logic [LURT_EPOCH_W-1:0] EPOCH_LAST  = '1;

  logic [LURT_EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic [POS_BITS-1:0] ws_r, ws_nxt;
  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic [POS_BITS-1:0] best_r, best_nxt;
  logic                ovf_r, ovf_nxt;

  logic [ENTRY_W-1:0]      entry;
  logic [LURT_EPOCH_W-1:0] lp_epoch;
  logic [POS_BITS-1:0] lp;
  logic                sat;
  logic                hit;
  logic [POS_BITS-1:0] ws_new;
  logic [POS_BITS-1:0] wlen_new;
  logic [POS_BITS-1:0] best_new;
  logic [POS_BITS-1:0] wlen_sel;
  logic [POS_BITS-1:0] best_sel;
  logic [EXT_W-1:0]    wlen_ext;
  logic [EXT_W-1:0]    best_ext;

  // The table entry written by the previous word may not have reached the read.
  assign entry    = fwd ? fwd_data : ram_rdata;
  assign lp       = entry[POS_BITS-1:0];
  assign lp_epoch = entry[ENTRY_W-1:POS_BITS];
  assign sat      = &pos_r;
  // An entry counts only if it was written while this string was running.
  assign hit      = (lp_epoch == epoch_r) && (lp >= ws_r);

  assign ws_new   = hit ? (lp + POS_BITS'(1)) : ws_r;
  assign wlen_new = pos_r - ws_new + POS_BITS'(1);
  assign best_new = (wlen_new > best_r) ? wlen_new : best_r;

  assign wlen_sel = sat ? (pos_r - ws_r) : wlen_new;
  assign best_sel = sat ? best_r : best_new;
  assign wlen_ext = EXT_W'(wlen_sel);
  assign best_ext = EXT_W'(best_sel);

  always_comb begin
    res.window_len  = (wlen_ext > EXT_W'(OUT_MAX)) ? OUT_MAX : wlen_ext[OUT_W-1:0];
    res.best_len    = (best_ext > EXT_W'(OUT_MAX)) ? OUT_MAX : best_ext[OUT_W-1:0];
    res.string_done = last;
    res.too_long    = sat | ovf_r;
  end

  assign wr_en      = step && !sat;
  assign wr_addr    = sym;
  assign wr_data    = {epoch_r, pos_r};
  assign epoch_full = (epoch_r == EPOCH_LAST);

  always_comb begin
    epoch_nxt = epoch_r;
    ws_nxt    = ws_r;
    pos_nxt   = pos_r;
    best_nxt  = best_r;
    ovf_nxt   = ovf_r;
    if (step) begin
      if (sat) begin
        ovf_nxt = 1'b1;
      end else begin
        ws_nxt   = ws_new;
        pos_nxt  = pos_r + POS_BITS'(1);
        best_nxt = best_new;
      end
      if (last) begin
        epoch_nxt = epoch_full ? EPOCH_FIRST : epoch_r + LURT_EPOCH_W'(1);
        ws_nxt    = '0;
        pos_nxt   = '0;
        best_nxt  = '0;
        ovf_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r <= EPOCH_FIRST;
      ws_r    <= '0;
      pos_r   <= '0;
      best_r  <= '0;
      ovf_r   <= 1'b0;
    end else begin
      epoch_r <= epoch_nxt;
      ws_r    <= ws_nxt;
      pos_r   <= pos_nxt;
      best_r  <= best_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

@@ rtl/longest_unique_run_tracker_top.sv @@
// Top level of the longest unique run tracker: front end, table, window and output.
// An accepted word is registered in stage one, and its result is registered in the output
// register, where it waits until taken.
// Throughput: one word per cycle through the table while the output is taken; the last word
// of every 255th string holds the input, then a clearing pass writes every table entry.
// Reset (synchronous, active low) clears window, counter and pipeline, then runs that pass.
module longest_unique_run_tracker_top #(
  parameter int POS_BITS = lurt_pkg::LURT_POS_BITS,
  parameter int ALPHABET = lurt_pkg::LURT_ALPHABET
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lurt_pkg::CHAR_W-1:0] in_char_in,
  input  logic                        in_end_of_string,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lurt_pkg::OUT_W-1:0]  out_window_len,
  output logic [lurt_pkg::OUT_W-1:0]  out_best_len,
  output logic                        out_string_done,
  output logic                        out_too_long
);
  import lurt_pkg::*;

  localparam int SYM_W   = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int ENTRY_W = LURT_EPOCH_W + POS_BITS;
  localparam logic [SYM_W-1:0] CLR_LAST   = SYM_W'(ALPHABET - 1);
  localparam logic [15:0]      ALPH_RECIP = 16'((65536 + ALPHABET - 1) / ALPHABET);
  localparam logic [8:0]       ALPH_C     = 9'(ALPHABET);

  // Stage one holds the word whose table entry is being read.
  logic                s1_valid_r;
  logic [SYM_W-1:0]    s1_sym_r;
  logic                s1_last_r;
  logic                fwd_r;
  logic [ENTRY_W-1:0]  fwd_data_r;

  logic                out_valid_r;
  result_t             out_res_r;

  // Clearing pass over the table, after reset and whenever the string tag wraps.
  logic                clr_r;
  logic [SYM_W-1:0]    clr_addr_r;

  logic                in_acc;
  logic                s1_adv;
  logic                wrap_hold;
  logic [23:0]         fold_prod;
  logic [CHAR_W-1:0]   fold_quo;
  logic [CHAR_W-1:0]   fold_back;
  logic [CHAR_W-1:0]   fold_rem;
  logic [SYM_W-1:0]    in_sym;

  logic                wr_en;
  logic [SYM_W-1:0]    wr_addr;
  logic [ENTRY_W-1:0]  wr_data;
  logic                epoch_full;
  logic                tbl_we;
  logic [SYM_W-1:0]    tbl_waddr;
  logic [ENTRY_W-1:0]  tbl_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;
  result_t             win_res;

  // Stage one moves on whenever the output register is empty or being emptied,
  // so a new word is taken while a finished result still waits downstream.
  // The last word of a string that uses up the final tag keeps the input closed,
  // because the clearing pass that follows must not race a table read.
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign wrap_hold = s1_valid_r && s1_last_r && epoch_full;
  assign in_ready  = !clr_r && !wrap_hold && (!s1_valid_r || s1_adv);
  assign in_acc    = in_valid && in_ready;

  // Bytes above the alphabet fold back: the quotient comes from a multiplication by
  // the rounded-up reciprocal, which is exact for every byte, and the remainder
  // is what is left after taking that many alphabets away.
  assign fold_prod = 24'(in_char_in) * 24'(ALPH_RECIP);
  assign fold_quo  = fold_prod[23:16];
  assign fold_back = CHAR_W'(16'(fold_quo) * 16'(ALPH_C));
  assign fold_rem  = in_char_in - fold_back;

  assign in_sym = fold_rem[SYM_W-1:0];

  // The clearing pass owns the write port; no word is in flight while it runs.
  assign tbl_we    = clr_r || wr_en;
  assign tbl_waddr = clr_r ? clr_addr_r : wr_addr;
  assign tbl_wdata = clr_r ? '0 : wr_data;

  lurt_table_ram #(
    .DEPTH  (ALPHABET),
    .DATA_W (ENTRY_W),
    .ADDR_W (SYM_W)
  ) u_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (in_acc),
    .raddr (in_sym),
    .rdata (ram_rdata)
  );

  lurt_window #(
    .POS_BITS (POS_BITS),
    .SYM_W    (SYM_W)
  ) u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (s1_adv),
    .sym        (s1_sym_r),
    .last       (s1_last_r),
    .ram_rdata  (ram_rdata),
    .fwd        (fwd_r),
    .fwd_data   (fwd_data_r),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .epoch_full (epoch_full),
    .res        (win_res)
  );

  // Every entry is written with tag zero, one entry per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_r) begin
      clr_addr_r <= clr_addr_r + SYM_W'(1);
      if (clr_addr_r == CLR_LAST) begin
        clr_r <= 1'b0;
      end
    end else if (s1_adv && s1_last_r && epoch_full) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end
  end

  // When the word ahead writes the entry this word reads in the same cycle,
  // the memory returns the old position, so the new one is captured here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sym_r   <= in_sym;
      s1_last_r  <= in_end_of_string;
      fwd_r      <= s1_adv && wr_en && (wr_addr == in_sym);
      fwd_data_r <= wr_data;
    end
  end

  // Output register: loaded as stage one advances, held until taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= win_res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_window_len  = out_res_r.window_len;
  assign out_best_len    = out_res_r.best_len;
  assign out_string_done = out_res_r.string_done;
  assign out_too_long    = out_res_r.too_long;

endmodule

@@ rtl/lurt_checker.sv @@
// Port-level checks for the longest unique run tracker, bound to the top level.
module lurt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_window_len,
  input logic [15:0] out_best_len,
  input logic        out_string_done,
  input logic        out_too_long
);

  // A stalled result word keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_window_len)
      && $stable(out_best_len) && $stable(out_string_done) && $stable(out_too_long))
    else $error("result word changed while stalled");

  // The best length never falls below the current window, and the window is never empty.
  a_best_ge_win: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_window_len <= out_best_len) && (out_window_len != 16'd0))
    else $error("window length exceeds best length or is zero");

  // A fresh result word traces back to an accepted input word that passed through stage one.
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result word without a matching input word");

endmodule

bind longest_unique_run_tracker_top lurt_checker u_lurt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_window_len  (out_window_len),
  .out_best_len    (out_best_len),
  .out_string_done (out_string_done),
  .out_too_long    (out_too_long)
);

@@ verif/tb_top.sv @@
// Testbench for the longest unique run tracker: stimulus, prediction and result checking.
module tb_top;
  import lurt_pkg::*;

  // Position count at which the counter is used up; a byte arriving at this count is not stored.
  localparam longint unsigned POS_LIMIT = (64'd1 << LURT_POS_BITS) - 64'd1;
  // How long the receiver holds off when the pressure phase asks for it.
  localparam int LONG_HOLD = 400;

  // How busy one side of the link is: normal random gaps, a rare single gap, or none.
  typedef enum int {PACE_NORMAL, PACE_LIGHT, PACE_NONE} pace_e;

  typedef logic [CHAR_W-1:0] char_q_t [$];

  // One pending input word with the idle cycles that follow its acceptance.
  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              eos;
    int                gap;
  } byte_item_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CHAR_W-1:0]    in_char_in = '0;
  logic                 in_end_of_string = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [OUT_W-1:0]     out_window_len;
  logic [OUT_W-1:0]     out_best_len;
  logic                 out_string_done;
  logic                 out_too_long;

  longest_unique_run_tracker_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_in       (in_char_in),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_window_len   (out_window_len),
    .out_best_len     (out_best_len),
    .out_string_done  (out_string_done),
    .out_too_long     (out_too_long)
  );

  always #4 clk = ~clk;

  // Words waiting to be offered, and result words predicted but not yet seen.
  byte_item_t stim_q [$];
  result_t    window_q [$];

  // Mirror of the window state inside the block.
  longint unsigned seen_at [LURT_ALPHABET];
  bit              seen [LURT_ALPHABET];
  longint unsigned run_start = 0;
  longint unsigned run_pos = 0;
  longint unsigned run_best = 0;
  bit              run_overflow = 1'b0;

  int    fail_count = 0;
  int    words_sent = 0;
  int    words_checked = 0;
  int    strings_done = 0;
  int    overflow_strings = 0;
  int    peak_best = 0;
  pace_e rx_mode = PACE_NORMAL;
  int    hold_req = 0;
  int    hold_done = 0;
  int    hold_left = 0;
  int    rx_stall = 0;
  int    tx_wait = 0;
  bit    tx_busy;
  byte_item_t tx_item;
  result_t    new_word;
  result_t    want;

  // Advance the window by one byte and return the result word the block must show for it.
  function automatic result_t advance_window(logic [CHAR_W-1:0] ch, logic eos);
    int              sym;
    longint unsigned wlen;
    result_t         r;
    sym = int'(ch) % LURT_ALPHABET;
    if (run_pos >= POS_LIMIT) begin
      // The counter has run out: nothing is stored and the last window length repeats.
      run_overflow = 1'b1;
      wlen = (run_pos >= run_start) ? run_pos - run_start : 0;
    end else begin
      // A repeat inside the window pulls the start just past the earlier copy.
      if (seen[sym] && seen_at[sym] >= run_start) begin
        run_start = seen_at[sym] + 1;
      end
      seen_at[sym] = run_pos;
      seen[sym] = 1'b1;
      wlen = run_pos - run_start + 1;
      if (wlen > run_best) begin
        run_best = wlen;
      end
      run_pos = run_pos + 1;
    end
    r.window_len  = (wlen > OUT_MAX) ? OUT_MAX : OUT_W'(wlen);
    r.best_len    = (run_best > OUT_MAX) ? OUT_MAX : OUT_W'(run_best);
    r.string_done = eos;
    r.too_long    = run_overflow;
    if (eos) begin
      foreach (seen[i]) seen[i] = 1'b0;
      run_start = 0;
      run_pos = 0;
      run_best = 0;
      run_overflow = 1'b0;
    end
    return r;
  endfunction

  function automatic int pick_gap(pace_e pace);
    int r;
    case (pace)
      PACE_NONE: begin
        return 0;
      end
      PACE_LIGHT: begin
        return ($urandom_range(0, 49) == 0) ? 1 : 0;
      end
      default: begin
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
      end
    endcase
  endfunction

  task automatic check_field(string name, logic [OUT_W-1:0] exp_val, logic [OUT_W-1:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  // Queue one string; its final byte carries the end mark.
  task automatic send_string(input char_q_t s, input pace_e pace);
    byte_item_t it;
    for (int i = 0; i < s.size(); i++) begin
      it.ch  = s[i];
      it.eos = (i == s.size() - 1);
      it.gap = pick_gap(pace);
      stim_q.push_back(it);
    end
  endtask

  // Let the sender go quiet until every predicted word has come back.
  task automatic drain();
    while (stim_q.size() != 0 || in_valid || window_q.size() != 0) @(negedge clk);
  endtask

  // Driver: offers queued words, holds each until accepted, and predicts on acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      tx_busy = in_valid && !in_ready;
      if (in_valid && in_ready) begin
        new_word = advance_window(in_char_in, in_end_of_string);
        window_q.push_back(new_word);
        words_sent++;
      end
      if (!tx_busy) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_valid <= 1'b0;
        end else if (stim_q.size() != 0) begin
          tx_item = stim_q.pop_front();
          tx_wait = tx_item.gap;
          in_valid <= 1'b1;
          in_char_in <= tx_item.ch;
          in_end_of_string <= tx_item.eos;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares every accepted result word with the oldest prediction and
  // paces out_ready, including the long hold-off that backs the block up.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (window_q.size() == 0) begin
          $error("result word with no prediction waiting: window_len %0d best_len %0d",
                 out_window_len, out_best_len);
          fail_count++;
        end else begin
          want = window_q.pop_front();
          check_field("window_len", want.window_len, out_window_len);
          check_field("best_len", want.best_len, out_best_len);
          check_field("string_done", OUT_W'(want.string_done), OUT_W'(out_string_done));
          check_field("too_long", OUT_W'(want.too_long), OUT_W'(out_too_long));
          words_checked++;
          if (want.string_done) strings_done++;
          if (want.string_done && want.too_long) overflow_strings++;
          if (int'(want.best_len) > peak_best) peak_best = int'(want.best_len);
        end
      end
      if (hold_done != hold_req) begin
        hold_done = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left == 0 && rx_stall == 0) begin
        if (rx_mode == PACE_LIGHT || (rx_mode == PACE_NORMAL && $urandom_range(0, 3) == 0)) begin
          rx_stall = pick_gap(rx_mode);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus: directed strings, a hold-off phase, enough short strings to use up the
  // string tags inside the block, then random strings. Apart from the reset release, all of it
  // acts at the falling edge to stay clear of the driver.
  initial begin
    char_q_t s;
    int      rand_items;
    int      rand_strings;
    int      kind;
    int      len;
    int      base;
    int      span;
    int      j;
    int      tmp;
    int      perm [LURT_ALPHABET];
    pace_e   pace;

    rand_items = 0;
    rand_strings = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // A one-byte string, then a byte that comes back right after a different one.
    s = '{8'h41};
    send_string(s, PACE_NORMAL);
    s = '{8'h00, 8'hFF, 8'h00};
    send_string(s, PACE_NORMAL);
    // Classic case whose best run is three.
    s = '{8'h61, 8'h62, 8'h63, 8'h61, 8'h62, 8'h63, 8'h62, 8'h62};
    send_string(s, PACE_NORMAL);
    // The earlier copy of the first byte lies before the window, so its return must not move it.
    s = '{8'h61, 8'h62, 8'h62, 8'h61};
    send_string(s, PACE_NORMAL);
    // Immediate repeat.
    s = '{8'h7F, 8'h7F};
    send_string(s, PACE_NORMAL);
    // Bytes from earlier strings: the marks must have been cleared at each end.
    s = '{8'h00, 8'hFF, 8'h41};
    send_string(s, PACE_NORMAL);
    drain();

    // The receiver holds off while the sender keeps offering back to back.
    hold_req++;
    for (int n = 0; n < 3; n++) begin
      s.delete();
      for (int i = 0; i < 30; i++) s.push_back(CHAR_W'($urandom_range(0, 255)));
      send_string(s, PACE_NONE);
    end
    drain();

    // Many two-byte strings over a tiny alphabet, so old table entries come back
    // after the string tags wrap around.
    for (int n = 0; n < 270; n++) begin
      s.delete();
      for (int i = 0; i < 2; i++) s.push_back(CHAR_W'($urandom_range(0, 3)));
      send_string(s, ($urandom_range(0, 1) == 0) ? PACE_NONE : PACE_NORMAL);
    end
    drain();

    // Random strings of mixed length and alphabet, with an occasional full permutation
    // so the window reaches the size of the alphabet.
    while (rand_items < 700) begin
      kind = $urandom_range(0, 99);
      pace = ($urandom_range(0, 5) == 0) ? PACE_NONE : PACE_NORMAL;
      rx_mode = ($urandom_range(0, 5) == 0) ? PACE_NONE : PACE_NORMAL;
      s.delete();
      if (kind < 4 || rand_items == 0) begin
        for (int i = 0; i < LURT_ALPHABET; i++) perm[i] = i;
        for (int i = LURT_ALPHABET - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = perm[i];
          perm[i] = perm[j];
          perm[j] = tmp;
        end
        for (int i = 0; i < LURT_ALPHABET; i++) s.push_back(CHAR_W'(perm[i]));
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++) s.push_back(CHAR_W'($urandom_range(0, 255)));
      end else begin
        len = (kind < 75) ? $urandom_range(1, 24) : $urandom_range(25, 120);
        if ($urandom_range(0, 1) == 0) begin
          for (int i = 0; i < len; i++) s.push_back(CHAR_W'($urandom_range(0, 255)));
        end else begin
          base = $urandom_range(0, 255);
          span = $urandom_range(1, 12);
          for (int i = 0; i < len; i++) begin
            s.push_back(CHAR_W'((base + $urandom_range(0, span - 1)) % 256));
          end
        end
      end
      send_string(s, pace);
      rand_items += s.size();
      rand_strings++;
      if (rand_strings % 8 == 0) drain();
    end
    drain();
    repeat (20) @(negedge clk);

    $display("Sent %0d words in %0d strings and checked %0d result words.",
             words_sent, strings_done, words_checked);
    $display("Longest run seen was %0d; %0d string(s) ran past the position counter.",
             peak_best, overflow_strings);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #16000000;
    $display("Run did not finish in time.");
    $display("FAIL");
    $finish;
  end

endmodule
